// ===== rtl/rht_pkg.sv =====
// Package for the request handle table: operation codes, controller states,
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package rht_pkg;

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;

  typedef enum logic [MODE_W-1:0] {
    OP_APPEND = 3'd0,
    OP_LATEST = 3'd1,
    OP_CAS    = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_ROOM   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;    // capture item, reset scan pointer and result
    logic append;  // store handle if room
    logic clear;   // empty the table
    logic issue;   // read next entry, top down
    logic found;   // current read data matched
    logic emit;    // move result into the output register
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic issue_left;
    logic rd_vld;
    logic rd_match;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/request_handle_table.sv =====
// Request handle table: an append-only table of up to CAPACITY handles with a
// fill count. One item is processed at a time. Append, clear, room query and
// unused modes pass from accept through the execute and finish states to the
// output register; latest and compare-and-swap read the memory top down one
// entry per cycle through its single registered read port, stopping early
// when a match is found. A finished result sits in the output register while
// the next item is accepted. Clear takes effect at once; no clearing pass
// runs after reset.
// Depends on rht_pkg, rht_ctrl and rht_dp.
`timescale 1ns / 1ps

module request_handle_table #(
  parameter int CAPACITY    = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // match_value[31:0], replace_value[63:32]
  input  logic [7:0]  s_tuser,   // mode[2:0], zero above
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // handle_out[31:0], hit[32], has_room[33], zero above
);
  import rht_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [VALUE_W-1:0] handle_out;
  logic               hit;
  logic               has_room;

  rht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  rht_dp #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (s_tuser[MODE_W-1:0]),
    .in_match   (s_tdata[VALUE_W-1:0]),
    .in_replace (s_tdata[2*VALUE_W-1:VALUE_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_handle (handle_out),
    .out_hit    (hit),
    .out_room   (has_room)
  );

  assign m_tdata = {6'd0, has_room, hit, handle_out};

endmodule

// ===== rtl/rht_ctrl.sv =====
// Controller of the request handle table: sequences one item at a time.
// Depends on rht_pkg.
`timescale 1ns / 1ps

module rht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output rht_pkg::dp_cmd_t  cmd,
  input  rht_pkg::dp_stat_t stat
);
  import rht_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.op == OP_LATEST || stat.op == OP_CAS) state_next = S_SCAN;
        else state_next = S_FINISH;
      end
      S_SCAN: begin
        if (stat.rd_vld && stat.rd_match) state_next = S_FINISH;
        else if (!stat.rd_vld && !stat.issue_left) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.append = (stat.op == OP_APPEND);
        cmd.clear  = (stat.op == OP_CLEAR);
      end
      S_SCAN: begin
        // stop issuing once a match shows up; reads in flight are dropped
        cmd.found = stat.rd_vld && stat.rd_match;
        cmd.issue = stat.issue_left && !(stat.rd_vld && stat.rd_match);
      end
      S_FINISH: begin
        cmd.emit = !stat.out_busy;
      end
      default: ;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_busy)
    else $error("result emitted over a pending item");

  a_found_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.found |=> state == S_FINISH)
    else $error("match did not end the scan");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_EXEC)
    else $error("accepted item not executed");

endmodule

// ===== rtl/rht_dp.sv =====
// Datapath of the request handle table: handle memory, fill count, scan
// pointer, result and output registers. Depends on rht_pkg.
`timescale 1ns / 1ps

module rht_dp #(
  parameter int CAPACITY    = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rht_pkg::dp_cmd_t             cmd,
  output rht_pkg::dp_stat_t            stat,
  input  logic [rht_pkg::MODE_W-1:0]   in_mode,
  input  logic [rht_pkg::VALUE_W-1:0]  in_match,
  input  logic [rht_pkg::VALUE_W-1:0]  in_replace,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rht_pkg::VALUE_W-1:0]  out_handle,
  output logic                         out_hit,
  output logic                         out_room
);
  import rht_pkg::*;

  localparam int STORE_W = (HANDLE_BITS < VALUE_W) ? HANDLE_BITS : VALUE_W;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [STORE_W-1:0] mem [CAPACITY];

  op_t                op;
  logic [STORE_W-1:0] mval;
  logic [STORE_W-1:0] rval;
  logic [CNT_W-1:0]   fill_count;
  logic [CNT_W-1:0]   ptr;        // entries still to read
  logic [STORE_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_vld;
  logic [STORE_W-1:0] res_handle;
  logic               res_hit;

  logic               room;
  logic [CNT_W-1:0]   ptr_dec;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [STORE_W-1:0] wr_data;

  assign room    = fill_count < CNT_W'(CAPACITY);
  assign ptr_dec = ptr - CNT_W'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_count[IDX_W-1:0];
    wr_data = mval;
    if (cmd.append && room) begin
      wr_en = 1'b1;
    end else if (cmd.found && op == OP_CAS) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx;
      wr_data = rval;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.issue) rd_data <= mem[ptr_dec[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= op_t'(in_mode);
      mval <= in_match[STORE_W-1:0];
      rval <= in_replace[STORE_W-1:0];
    end
    if (cmd.issue) rd_idx <= ptr_dec[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      ptr        <= '0;
      rd_vld     <= 1'b0;
      res_handle <= '0;
      res_hit    <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.load) begin
        ptr        <= fill_count;
        res_handle <= '0;
        res_hit    <= 1'b0;
      end else if (cmd.issue) begin
        ptr <= ptr_dec;
      end
      if (cmd.append && room) begin
        fill_count <= fill_count + CNT_W'(1);
        res_handle <= mval;
      end
      // entries are rewritten by append before any read, so no sweep
      if (cmd.clear) fill_count <= '0;
      if (cmd.found) begin
        if (op == OP_CAS) res_hit <= 1'b1;
        else res_handle <= rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_handle <= VALUE_W'(res_handle);
      out_hit    <= res_hit;
      out_room   <= room;
    end
  end

  always_comb begin
    stat.op         = op;
    stat.issue_left = (ptr != '0);
    stat.rd_vld     = rd_vld;
    stat.rd_match   = (op == OP_CAS) ? (rd_data == mval) : (rd_data != '0);
    stat.out_busy   = out_valid && !out_ready;
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_read_below: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> CNT_W'(rd_idx) < fill_count)
    else $error("read of an entry above the fill count");

  a_hit_cas: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && res_hit |-> op == OP_CAS)
    else $error("hit reported for a non compare-and-swap item");

endmodule

// ===== dv/request_handle_table_tb.sv =====
// Self-checking testbench for request_handle_table: a queue-fed stream driver, a
// result monitor and an in-bench handle table predictor. Depends on rht_pkg and
// the request_handle_table RTL.
`timescale 1ns / 1ps

module request_handle_table_tb;
  import rht_pkg::*;

  localparam int CAPACITY    = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TARGET = 1250;
  localparam int TAIL_ITEMS  = 150;
  localparam int MAX_REPORTS = 50;
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] match_value;
    logic [31:0] replace_value;
  } handle_req_t;

  typedef struct {
    logic [31:0] handle;
    logic        hit;
    logic        room;
  } handle_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // match_value[31:0], replace_value[63:32]
  logic [7:0]  s_tuser = '0;   // mode[2:0], zero above
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // handle_out[31:0], hit[32], has_room[33], zero above

  handle_req_t    pending[$];
  handle_result_t results_due[$];

  // predictor state
  logic [31:0] tbl_entries[CAPACITY];
  int          tbl_count = 0;

  int   errors = 0;
  int   idle_cycles = 0;
  logic in_taken = 1'b0;
  int   src_gap = 0;
  int   src_calm = 0;
  int   snk_gap = 0;
  int   snk_calm = 0;
  logic tail;

  request_handle_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // no idling once the queue runs low
  assign tail = (pending.size() <= TAIL_ITEMS);

  function automatic handle_result_t apply_request(logic [2:0] mode, logic [31:0] mval,
                                                   logic [31:0] rval);
    handle_result_t r;
    int i;
    logic done;
    r.handle = '0;
    r.hit = 1'b0;
    done = 1'b0;
    case (mode)
      OP_APPEND: begin
        if (tbl_count < CAPACITY) begin
          tbl_entries[tbl_count] = mval;
          r.handle = mval;
          tbl_count = tbl_count + 1;
        end
      end
      OP_LATEST: begin
        for (i = tbl_count - 1; i >= 0 && !done; i--) begin
          if (tbl_entries[i] != '0) begin
            r.handle = tbl_entries[i];
            done = 1'b1;
          end
        end
      end
      OP_CAS: begin
        for (i = tbl_count - 1; i >= 0 && !done; i--) begin
          if (tbl_entries[i] == mval) begin
            tbl_entries[i] = rval;
            r.hit = 1'b1;
            done = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < tbl_count; i++) tbl_entries[i] = '0;
        tbl_count = 0;
      end
      default: ;
    endcase
    r.room = (tbl_count < CAPACITY);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (errors < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors = errors + 1;
    end
  endtask

  function automatic logic [31:0] pick_handle();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(logic [2:0] mode, logic [31:0] mval, logic [31:0] rval);
    handle_req_t q;
    q.mode = mode;
    q.match_value = mval;
    q.replace_value = rval;
    pending.push_back(q);
  endtask

  // source: hold an item until taken, then idle in short bursts
  always @(negedge clk) begin
    if (src_calm != 0) src_calm <= src_calm - 1;
    else if ($urandom_range(0, 39) == 0) src_calm <= $urandom_range(20, 80);
    if (!rst && (!s_tvalid || in_taken)) begin
      if (src_gap != 0) begin
        s_tvalid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (!tail && src_calm == 0 && $urandom_range(0, 5) == 0) begin
        s_tvalid <= 1'b0;
        src_gap <= $urandom_range(0, 2);
      end else if (pending.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pending[0].replace_value, pending[0].match_value};
        s_tuser <= {5'b0, pending[0].mode};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink backpressure
  always @(negedge clk) begin
    if (snk_calm != 0) snk_calm <= snk_calm - 1;
    else if ($urandom_range(0, 39) == 0) snk_calm <= $urandom_range(20, 80);
    if (snk_gap != 0) begin
      m_tready <= 1'b0;
      snk_gap <= snk_gap - 1;
    end else if (!tail && snk_calm == 0 && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      snk_gap <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // input capture, result check and watchdog
  always @(posedge clk) begin
    handle_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        results_due.push_back(apply_request(s_tuser[2:0], s_tdata[31:0], s_tdata[63:32]));
        pending.delete(0);
      end
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t ns: unexpected item, expected none, actual %h", $time, m_tdata);
          errors = errors + 1;
        end else begin
          want = results_due.pop_front();
          check_field("handle_out", want.handle, m_tdata[31:0]);
          check_field("hit", {31'b0, want.hit}, {31'b0, m_tdata[32]});
          check_field("has_room", {31'b0, want.room}, {31'b0, m_tdata[33]});
          check_field("padding", 32'h0, {26'b0, m_tdata[39:34]});
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] recent[$];
    logic [31:0] m;
    logic [31:0] r;
    int n_real;
    int n_app;
    int len;
    int k;
    logic first;

    // directed part
    push_req(OP_ROOM, 32'h0, 32'h0);
    push_req(OP_LATEST, 32'h0, 32'h0);            // empty table
    push_req(OP_CAS, 32'h0, 32'h1234_5678);       // empty, no hit
    push_req(OP_APPEND, 32'h0, 32'hFFFF_FFFF);    // zero still counts
    push_req(OP_LATEST, 32'hFFFF_FFFF, 32'h0);    // only zero entries
    push_req(OP_APPEND, 32'hFFFF_FFFF, 32'h0);
    push_req(OP_APPEND, 32'h0000_0001, 32'h0);
    push_req(OP_LATEST, 32'h0, 32'h0);
    push_req(OP_CAS, 32'hFFFF_FFFF, 32'h0);       // hit, entry goes to zero
    push_req(OP_CAS, 32'h1234_5678, 32'h9ABC_DEF0); // miss
    push_req(OP_CAS, 32'h0, 32'hAAAA_AAAA);       // matches newest zero
    push_req(OP_LATEST, 32'h0, 32'h0);
    push_req(MODE_SPARE_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(MODE_SPARE_FIRST + 3'd1, 32'h5555_5555, 32'hAAAA_AAAA);
    push_req(MODE_SPARE_LAST, 32'h8000_0000, 32'h0000_0001);
    push_req(OP_ROOM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(OP_CLEAR, 32'h0, 32'h0);
    push_req(OP_LATEST, 32'h0, 32'h0);
    push_req(OP_CAS, 32'h0, 32'h1);               // zero match on empty table
    push_req(OP_APPEND, 32'h8000_0000, 32'h0);
    push_req(OP_CAS, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(OP_LATEST, 32'h0, 32'h0);

    // random sessions: clear, then appends mixed with lookups, swaps, room queries, unused modes and clears
    n_real = 0;
    first = 1'b1;
    while (n_real < ITEM_TARGET) begin
      push_req(OP_CLEAR, $urandom, $urandom);
      n_real++;
      recent.delete();
      if (first || $urandom_range(0, 3) == 0) n_app = $urandom_range(30, 36);
      else n_app = $urandom_range(0, 10);
      first = 1'b0;
      len = 2 * n_app + $urandom_range(4, 12);
      for (k = 0; k < len; k++) begin
        if (n_app > 0 && $urandom_range(0, 2) != 0) begin
          m = pick_handle();
          push_req(OP_APPEND, m, $urandom);
          recent.push_back(m);
          n_app--;
          n_real++;
        end else begin
          case ($urandom_range(0, 11))
            0, 1, 2, 3: begin
              push_req(OP_LATEST, $urandom, $urandom);
              n_real++;
            end
            4, 5, 6, 7: begin
              if (recent.size() != 0 && $urandom_range(0, 4) != 0)
                m = recent[$urandom_range(0, recent.size() - 1)];
              else
                m = pick_handle();
              r = pick_handle();
              push_req(OP_CAS, m, r);
              recent.push_back(r);
              n_real++;
            end
            8, 9: begin
              push_req(OP_ROOM, $urandom, $urandom);
              n_real++;
            end
            10: push_req(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                         $urandom, $urandom);
            default: begin
              push_req(OP_CLEAR, $urandom, $urandom);
              recent.delete();
              n_real++;
            end
          endcase
        end
      end
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || results_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
